// ===== design/dcs_pkg.sv =====
package dcs_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int RATE_W = 16;
	localparam int VAL_W = 11;
	localparam int TIME_W = 32;
	localparam int PROD_W = TIME_W + RATE_W;
	localparam int STEP_W = 21;
	localparam int SCALED_W = 26;
	localparam int QUOT_W = 17;
	localparam int RECIP_SHIFT = 35;

	localparam logic [2:0] FUNC_THROTTLE = 3'd0;
	localparam logic [2:0] FUNC_STEERING = 3'd1;
	localparam logic [2:0] FUNC_ESTOP = 3'd2;
	localparam logic [2:0] FUNC_SAFETY = 3'd3;
	localparam logic [2:0] FUNC_RELEASE = 3'd4;

	localparam logic [1:0] REG_THROTTLE_RATE = 2'd0;
	localparam logic [1:0] REG_STEERING_RATE = 2'd1;
	localparam logic [1:0] REG_STOP_DECEL_RATE = 2'd2;

	localparam logic [RATE_W-1:0] THROTTLE_RATE_RST = 16'd128;
	localparam logic [RATE_W-1:0] STEERING_RATE_RST = 16'd128;
	localparam logic [RATE_W-1:0] STOP_DECEL_RATE_RST = 16'd256;

	localparam logic signed [VAL_W-1:0] CMD_MAX = 11'sd1000;
	localparam logic signed [VAL_W-1:0] CMD_MIN = -11'sd1000;
	localparam logic signed [VAL_W-1:0] HIST_BAND = 11'sd250;
	localparam logic signed [VAL_W-1:0] RELEASE_BAND = 11'sd300;
	localparam logic signed [VAL_W-1:0] REV_LEVEL = 11'sd800;
	localparam logic [TIME_W-1:0] REV_WINDOW = 32'd150;

	localparam logic [STEP_W-1:0] STEP_CAP = 21'd32000;
	localparam logic [STEP_W-1:0] STEP_LIMIT = 21'd1048576;
	localparam logic [VAL_W-1:0] SCALE_BASE = 11'd1000;
	localparam logic [SCALED_W-1:0] SCALED_CAP = 26'd32000000;
	localparam logic [SCALED_W-1:0] RECIP_M = 26'd34359739;

	typedef struct packed {
		logic [RATE_W-1:0] throttle_rate;
		logic [RATE_W-1:0] steering_rate;
		logic [RATE_W-1:0] stop_decel_rate;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic check;
		logic mul;
		logic scale;
		logic recip;
		logic apply;
	} ctl_cmd_t;

	typedef struct packed {
		logic opposite;
	} ctl_stat_t;

	function automatic logic opposite(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b);
		return (a < 0 && b > 0) || (a > 0 && b < 0);
	endfunction

endpackage

// ===== design/dcs_if.sv =====
interface dcs_in_if;
	logic valid;
	logic ready;
	logic [2:0] func;
	logic signed [10:0] command_value;
	logic [31:0] timestamp_ms;

	modport source (output valid, func, command_value, timestamp_ms, input ready);
	modport sink (input valid, func, command_value, timestamp_ms, output ready);
endinterface

interface dcs_out_if;
	logic valid;
	logic ready;
	logic signed [10:0] applied_throttle;
	logic signed [10:0] applied_steering;
	logic estop_active;
	logic safety_stop_active;
	logic quick_reversal;

	modport source (output valid, applied_throttle, applied_steering, estop_active,
		safety_stop_active, quick_reversal, input ready);
	modport sink (input valid, applied_throttle, applied_steering, estop_active,
		safety_stop_active, quick_reversal, output ready);
endinterface

// ===== design/dcs_regs.sv =====
module dcs_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [dcs_pkg::ADDR_W-1:0] paddr,
	input logic [dcs_pkg::DATA_W-1:0] pwdata,
	output logic [dcs_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output dcs_pkg::cfg_t cfg
);

	dcs_pkg::cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.throttle_rate <= dcs_pkg::THROTTLE_RATE_RST;
			cfg_q.steering_rate <= dcs_pkg::STEERING_RATE_RST;
			cfg_q.stop_decel_rate <= dcs_pkg::STOP_DECEL_RATE_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				dcs_pkg::REG_THROTTLE_RATE: cfg_q.throttle_rate <= pwdata[15:0];
				dcs_pkg::REG_STEERING_RATE: cfg_q.steering_rate <= pwdata[15:0];
				dcs_pkg::REG_STOP_DECEL_RATE: cfg_q.stop_decel_rate <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			dcs_pkg::REG_THROTTLE_RATE: prdata = {16'd0, cfg_q.throttle_rate};
			dcs_pkg::REG_STEERING_RATE: prdata = {16'd0, cfg_q.steering_rate};
			dcs_pkg::REG_STOP_DECEL_RATE: prdata = {16'd0, cfg_q.stop_decel_rate};
			default: prdata = '0;
		endcase
	end

endmodule

// ===== design/dcs_ctrl.sv =====
module dcs_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input dcs_pkg::ctl_stat_t stat,
	output dcs_pkg::ctl_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_MUL   = 6'b000100,
		S_SCALE = 6'b001000,
		S_RECIP = 6'b010000,
		S_APPLY = 6'b100000
	} state_t;

	state_t state_q, state_next;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_next = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_next = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_next = stat.opposite ? S_SCALE : S_APPLY;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_next = S_RECIP;
			end
			S_RECIP: begin
				cmd.recip = 1'b1;
				state_next = S_APPLY;
			end
			S_APPLY: begin
				if (!out_valid_q || out_ready) begin
					cmd.apply = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.apply) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/dcs_dp.sv =====
module dcs_dp (
	input logic clk,
	input logic arst_n,
	input dcs_pkg::cfg_t cfg,
	input dcs_pkg::ctl_cmd_t cmd,
	output dcs_pkg::ctl_stat_t stat,
	input logic [2:0] in_func,
	input logic signed [dcs_pkg::VAL_W-1:0] in_command_value,
	input logic [dcs_pkg::TIME_W-1:0] in_timestamp_ms,
	output logic signed [dcs_pkg::VAL_W-1:0] out_throttle,
	output logic signed [dcs_pkg::VAL_W-1:0] out_steering,
	output logic out_estop,
	output logic out_safety,
	output logic out_quick
);

	// captured word
	logic [2:0] func_q;
	logic signed [dcs_pkg::VAL_W-1:0] cmd_q;
	logic [dcs_pkg::TIME_W-1:0] now_q;
	logic signed [dcs_pkg::VAL_W-1:0] cmd_sat;

	// block state
	logic signed [dcs_pkg::VAL_W-1:0] thr_q, str_q, hist_new_q, hist_old_q;
	logic [dcs_pkg::TIME_W-1:0] thr_stamp_q, str_stamp_q, rev_stamp_q;
	logic estop_q, safety_q, quick_q;

	// reversal check
	logic check_en, in_hist_band, rev_hit, fire;
	logic signed [dcs_pkg::VAL_W:0] hist_sum;
	logic [dcs_pkg::VAL_W-1:0] avg_bits;
	logic signed [dcs_pkg::VAL_W-1:0] hist_avg;
	logic [dcs_pkg::TIME_W-1:0] rev_stamp_eff, rev_age;

	// ramp selection and product
	logic is_thr;
	logic signed [dcs_pkg::VAL_W-1:0] sel_value, sel_target;
	logic [dcs_pkg::TIME_W-1:0] sel_stamp, dt;
	logic [dcs_pkg::RATE_W-1:0] sel_rate;
	logic [dcs_pkg::PROD_W-1:0] prod_s1;
	logic signed [dcs_pkg::VAL_W-1:0] val_s1, tgt_s1;
	logic opp_s1, cap_s1, rate_zero_s1;

	// opposite-sign scaling
	logic [dcs_pkg::VAL_W-1:0] tgt_mag;
	logic [dcs_pkg::SCALED_W-1:0] scaled_s2;
	logic big_s2;
	logic [2*dcs_pkg::SCALED_W-1:0] recip_prod;
	logic [dcs_pkg::QUOT_W-1:0] quot_s3;
	logic over_s3;

	// update
	logic [dcs_pkg::STEP_W-1:0] step;
	logic down;
	logic signed [22:0] val_q8, q_sum;
	logic [14:0] r_bits;
	logic signed [14:0] r_trunc, tgt15;
	logic signed [dcs_pkg::VAL_W-1:0] ramp_hit, ramp_value;
	logic signed [dcs_pkg::VAL_W-1:0] thr_next, str_next;
	logic [dcs_pkg::TIME_W-1:0] thr_stamp_next, str_stamp_next;
	logic estop_next, safety_next;

	always_comb begin
		if (in_command_value > dcs_pkg::CMD_MAX) begin
			cmd_sat = dcs_pkg::CMD_MAX;
		end else if (in_command_value < dcs_pkg::CMD_MIN) begin
			cmd_sat = dcs_pkg::CMD_MIN;
		end else begin
			cmd_sat = in_command_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			cmd_q <= cmd_sat;
			now_q <= in_timestamp_ms;
		end
	end

	// quick reversal against the history average
	assign check_en = (func_q == dcs_pkg::FUNC_THROTTLE) && !estop_q && !safety_q;
	assign in_hist_band = (cmd_q > -dcs_pkg::HIST_BAND) && (cmd_q < dcs_pkg::HIST_BAND);
	assign hist_sum = {hist_new_q[dcs_pkg::VAL_W-1], hist_new_q}
		+ {hist_old_q[dcs_pkg::VAL_W-1], hist_old_q};
	assign avg_bits = hist_sum[dcs_pkg::VAL_W:1]
		+ {{(dcs_pkg::VAL_W-1){1'b0}}, hist_sum[dcs_pkg::VAL_W] & hist_sum[0]};
	assign hist_avg = $signed(avg_bits);
	assign rev_hit = dcs_pkg::opposite(hist_avg, cmd_q);
	assign rev_stamp_eff = rev_hit ? now_q : rev_stamp_q;
	assign rev_age = now_q - rev_stamp_eff;
	assign fire = !in_hist_band
		&& (cmd_q >= dcs_pkg::REV_LEVEL || cmd_q <= -dcs_pkg::REV_LEVEL)
		&& (rev_age <= dcs_pkg::REV_WINDOW);

	// ramp operand selection
	assign is_thr = (func_q == dcs_pkg::FUNC_THROTTLE);
	assign sel_value = is_thr ? thr_q : str_q;
	assign sel_stamp = is_thr ? thr_stamp_q : str_stamp_q;
	assign sel_target = safety_q ? '0 : cmd_q;
	always_comb begin
		if (safety_q) begin
			sel_rate = cfg.stop_decel_rate;
		end else if (is_thr) begin
			sel_rate = cfg.throttle_rate;
		end else begin
			sel_rate = cfg.steering_rate;
		end
	end
	assign dt = now_q - sel_stamp;
	assign stat.opposite = dcs_pkg::opposite(sel_value, sel_target);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= dt * sel_rate;
			val_s1 <= sel_value;
			tgt_s1 <= sel_target;
			opp_s1 <= stat.opposite;
			cap_s1 <= !safety_q;
			rate_zero_s1 <= (sel_rate == '0);
		end
	end

	// step * (1000 + |target|) / 1000, divide by reciprocal
	assign tgt_mag = (tgt_s1 < 0) ? $unsigned(-tgt_s1) : $unsigned(tgt_s1);
	assign recip_prod = scaled_s2 * dcs_pkg::RECIP_M;

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			scaled_s2 <= prod_s1[14:0] * (dcs_pkg::SCALE_BASE + tgt_mag);
			big_s2 <= (prod_s1 >= dcs_pkg::PROD_W'(dcs_pkg::STEP_CAP));
		end
		if (cmd.recip) begin
			quot_s3 <= recip_prod[dcs_pkg::RECIP_SHIFT+dcs_pkg::QUOT_W-1:dcs_pkg::RECIP_SHIFT];
			over_s3 <= big_s2 || (scaled_s2 > dcs_pkg::SCALED_CAP);
		end
	end

	// step and new value
	always_comb begin
		if (opp_s1) begin
			step = over_s3 ? dcs_pkg::STEP_CAP
				: {{(dcs_pkg::STEP_W-dcs_pkg::QUOT_W){1'b0}}, quot_s3};
		end else if (cap_s1 && prod_s1 > dcs_pkg::PROD_W'(dcs_pkg::STEP_CAP)) begin
			step = dcs_pkg::STEP_CAP;
		end else if (prod_s1 > dcs_pkg::PROD_W'(dcs_pkg::STEP_LIMIT)) begin
			step = dcs_pkg::STEP_LIMIT;
		end else begin
			step = prod_s1[dcs_pkg::STEP_W-1:0];
		end
	end

	assign down = (val_s1 > tgt_s1);
	assign val_q8 = {{4{val_s1[dcs_pkg::VAL_W-1]}}, val_s1, 8'd0};
	assign q_sum = down ? (val_q8 - $signed({2'b00, step})) : (val_q8 + $signed({2'b00, step}));
	assign r_bits = q_sum[22:8] + {14'd0, q_sum[22] & (|q_sum[7:0])};
	assign r_trunc = $signed(r_bits);
	assign tgt15 = {{4{tgt_s1[dcs_pkg::VAL_W-1]}}, tgt_s1};

	always_comb begin
		if (down) begin
			ramp_hit = (r_trunc < tgt15) ? tgt_s1 : r_trunc[dcs_pkg::VAL_W-1:0];
		end else begin
			ramp_hit = (r_trunc > tgt15) ? tgt_s1 : r_trunc[dcs_pkg::VAL_W-1:0];
		end
		if (rate_zero_s1 || val_s1 == tgt_s1) begin
			ramp_value = val_s1;
		end else begin
			ramp_value = ramp_hit;
		end
	end

	always_comb begin
		thr_next = thr_q;
		str_next = str_q;
		thr_stamp_next = thr_stamp_q;
		str_stamp_next = str_stamp_q;
		estop_next = estop_q;
		safety_next = safety_q;
		unique case (func_q)
			dcs_pkg::FUNC_THROTTLE: begin
				if (estop_q) begin
					thr_next = '0;
				end else begin
					thr_next = ramp_value;
					if (!rate_zero_s1) begin
						thr_stamp_next = now_q;
					end
					if (safety_q && cmd_q > -dcs_pkg::RELEASE_BAND
						&& cmd_q < dcs_pkg::RELEASE_BAND) begin
						safety_next = 1'b0;
					end
				end
			end
			dcs_pkg::FUNC_STEERING: begin
				if (estop_q) begin
					str_next = '0;
				end else begin
					str_next = ramp_value;
					if (!rate_zero_s1) begin
						str_stamp_next = now_q;
					end
				end
			end
			dcs_pkg::FUNC_ESTOP: begin
				estop_next = 1'b1;
				thr_next = '0;
				str_next = '0;
			end
			dcs_pkg::FUNC_SAFETY: safety_next = 1'b1;
			dcs_pkg::FUNC_RELEASE: begin
				estop_next = 1'b0;
				safety_next = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			str_q <= '0;
			thr_stamp_q <= '0;
			str_stamp_q <= '0;
			rev_stamp_q <= '0;
			hist_new_q <= '0;
			hist_old_q <= '0;
			estop_q <= 1'b0;
			safety_q <= 1'b0;
		end else if (cmd.check) begin
			if (check_en) begin
				if (in_hist_band) begin
					hist_old_q <= hist_new_q;
					hist_new_q <= cmd_q;
				end else begin
					rev_stamp_q <= rev_stamp_eff;
					if (fire) begin
						safety_q <= 1'b1;
					end else begin
						hist_old_q <= hist_new_q;
						hist_new_q <= cmd_q;
					end
				end
			end
		end else if (cmd.apply) begin
			thr_q <= thr_next;
			str_q <= str_next;
			thr_stamp_q <= thr_stamp_next;
			str_stamp_q <= str_stamp_next;
			estop_q <= estop_next;
			safety_q <= safety_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			quick_q <= check_en && !in_hist_band && fire;
		end
		if (cmd.apply) begin
			out_throttle <= thr_next;
			out_steering <= str_next;
			out_estop <= estop_next;
			out_safety <= safety_next;
			out_quick <= quick_q;
		end
	end

endmodule

// ===== design/drive_command_slew_with_safety_stop.sv =====
// channel   dir   words carried
// req       in    func, command_value, timestamp_ms
// rsp       out   applied_throttle, applied_steering, estop_active,
//                 safety_stop_active, quick_reversal
// apb       in    throttle_rate, steering_rate, stop_decel_rate
//
// result register loads in the apply state, after check and multiply states;
// scale multiply and reciprocal multiply by 1/1000 precede it when the current
// value and the target have opposite signs; next word accepted the cycle after
// the update; one word in flight; req ready only while the controller is idle
// a result waiting on rsp stalls the update cycle until the register frees
// reset clears state, rates to their defaults, no clearing pass
module drive_command_slew_with_safety_stop (
	input logic clk,
	input logic arst_n,
	dcs_in_if.sink req,
	dcs_out_if.source rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [dcs_pkg::ADDR_W-1:0] paddr,
	input logic [dcs_pkg::DATA_W-1:0] pwdata,
	output logic [dcs_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	dcs_pkg::cfg_t cfg;
	dcs_pkg::ctl_cmd_t cmd;
	dcs_pkg::ctl_stat_t stat;
	logic in_ready, out_valid;

	dcs_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	dcs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(rsp.ready),
		.stat(stat),
		.cmd(cmd)
	);

	dcs_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd(cmd),
		.stat(stat),
		.in_func(req.func),
		.in_command_value(req.command_value),
		.in_timestamp_ms(req.timestamp_ms),
		.out_throttle(rsp.applied_throttle),
		.out_steering(rsp.applied_steering),
		.out_estop(rsp.estop_active),
		.out_safety(rsp.safety_stop_active),
		.out_quick(rsp.quick_reversal)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

endmodule

// ===== design/dcs_checker.sv =====
module dcs_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic signed [10:0] applied_throttle,
	input logic signed [10:0] applied_steering,
	input logic estop_active,
	input logic safety_stop_active,
	input logic quick_reversal
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(applied_throttle)
			&& $stable(applied_steering))
		else $error("rsp word changed while stalled");

	a_estop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && estop_active |-> applied_throttle == 0 && applied_steering == 0)
		else $error("nonzero output during e-stop");

	a_quick_stop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && quick_reversal |-> safety_stop_active && !estop_active)
		else $error("quick reversal without safety stop");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second word accepted while busy");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> applied_throttle >= -11'sd1000 && applied_throttle <= 11'sd1000
			&& applied_steering >= -11'sd1000 && applied_steering <= 11'sd1000)
		else $error("applied value out of range");

endmodule

bind drive_command_slew_with_safety_stop dcs_checker u_dcs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.applied_throttle(rsp.applied_throttle),
	.applied_steering(rsp.applied_steering),
	.estop_active(rsp.estop_active),
	.safety_stop_active(rsp.safety_stop_active),
	.quick_reversal(rsp.quick_reversal)
);
